### hdl/gae_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gae_pkg
// Shared constants, types and state codes of the advantage estimation engine.
// ----------------------------------------------------------------------------
package gae_pkg;

    localparam int MAX_STEPS = 64;
    localparam int ADDR_W    = (MAX_STEPS > 1) ? $clog2(MAX_STEPS) : 1;
    localparam int CNT_W     = $clog2(MAX_STEPS + 1);
    localparam int DATA_W    = 32;
    localparam int COEF_W    = 16;
    localparam int FRAC_W    = 16;
    localparam int PROD_W    = DATA_W + COEF_W + 1;
    localparam int SHR_W     = PROD_W - FRAC_W;
    localparam int ACC_W     = DATA_W + 3;

    localparam logic [COEF_W-1:0] GAMMA_RESET  = 16'd64881;
    localparam logic [COEF_W-1:0] LAMBDA_RESET = 16'd62259;

    localparam logic REG_DISCOUNT = 1'b0;
    localparam logic REG_TRACE    = 1'b1;

    typedef struct packed {
        logic signed [DATA_W-1:0] reward;
        logic signed [DATA_W-1:0] value;
        logic                     done;
    } t_step;

    localparam int STEP_W = $bits(t_step);

    typedef enum logic [2:0] {
        S_IDLE,
        S_GL,
        S_VLAST,
        S_MUL1,
        S_MUL2,
        S_SUM,
        S_EMIT
    } t_state;

endpackage

### hdl/gae_advantage_engine.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gae_advantage_engine
// Generalised advantage estimation over one stored trajectory in Q16.16.
// ----------------------------------------------------------------------------
// A non-final item is stored, or dropped if the store is full; busy stays low.
// A final item over n stored steps keeps busy high through the backward sweep
// and the read-out: two products of the shared multiplier per step of the sweep,
// then one memory read per result. Results follow one per cycle, the first one
// once the sweep ends. The receiver cannot stall.
// Synchronous active-low reset clears control state; the stores are not cleared.
module gae_advantage_engine import gae_pkg::*; (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_start,
    output logic                     o_busy,
    input  logic signed [DATA_W-1:0] i_reward,
    input  logic signed [DATA_W-1:0] i_value_estimate,
    input  logic                     i_episode_done,
    input  logic                     i_final_step,
    output logic                     o_strobe,
    output logic signed [DATA_W-1:0] o_advantage,
    output logic                     o_last_result,
    output logic                     o_truncated,
    input  logic                     i_cfg_valid,
    output logic                     o_cfg_ready,
    input  logic                     i_cfg_index,
    input  logic [COEF_W-1:0]        i_cfg_data
);

    t_state r_state;
    t_state n_state;

    logic [COEF_W-1:0]        r_gamma;
    logic [COEF_W-1:0]        r_lambda;
    logic [COEF_W-1:0]        r_gl;
    logic [CNT_W-1:0]         r_count;
    logic                     r_overflow;
    logic [ADDR_W-1:0]        r_last_idx;
    logic [ADDR_W-1:0]        r_idx;
    logic signed [DATA_W-1:0] r_v_next;
    logic signed [DATA_W-1:0] r_adv_next;
    logic signed [DATA_W-1:0] r_cur_v;
    logic                     r_cur_done;
    logic signed [ACC_W-1:0]  r_acc;
    logic                     r_out_strobe;
    logic                     r_out_last;
    logic                     r_out_trunc;

    logic                     accept;
    logic                     store_full;

    logic                     step_we;
    logic [ADDR_W-1:0]        step_waddr;
    logic                     step_re;
    logic [ADDR_W-1:0]        step_raddr;
    logic [STEP_W-1:0]        step_rdata;
    t_step                    step_wr;
    t_step                    step_rd;

    logic                     adv_we;
    logic [ADDR_W-1:0]        adv_waddr;
    logic [DATA_W-1:0]        adv_wdata;
    logic                     adv_re;
    logic [DATA_W-1:0]        adv_rdata;

    logic [COEF_W-1:0]        mul_coef;
    logic signed [DATA_W-1:0] mul_opnd;
    logic signed [PROD_W-1:0] mul_prod;
    logic signed [SHR_W-1:0]  prod_shr;
    logic signed [ACC_W-1:0]  sum;
    logic signed [DATA_W-1:0] sum_sat;

    assign accept      = i_start && (r_state == S_IDLE);
    assign store_full  = (r_count == CNT_W'(MAX_STEPS));
    assign o_busy      = (r_state != S_IDLE);
    assign o_cfg_ready = 1'b1;

    assign step_wr.reward = i_reward;
    assign step_wr.value  = i_value_estimate;
    assign step_wr.done   = i_episode_done;
    assign step_rd        = t_step'(step_rdata);

    assign prod_shr = mul_prod[PROD_W-1:FRAC_W];
    assign sum      = r_acc + ACC_W'(prod_shr);

    always_comb begin
        if (sum > ACC_W'(signed'(32'sh7FFF_FFFF))) begin
            sum_sat = 32'sh7FFF_FFFF;
        end else if (sum < ACC_W'(signed'(32'sh8000_0000))) begin
            sum_sat = 32'sh8000_0000;
        end else begin
            sum_sat = sum[DATA_W-1:0];
        end
    end

    gae_ram #(
        .DATA_W (STEP_W),
        .ADDR_W (ADDR_W)
    ) u_step_ram (
        .i_clk   (i_clk),
        .i_we    (step_we),
        .i_waddr (step_waddr),
        .i_wdata (step_wr),
        .i_re    (step_re),
        .i_raddr (step_raddr),
        .o_rdata (step_rdata)
    );

    gae_ram #(
        .DATA_W (DATA_W),
        .ADDR_W (ADDR_W)
    ) u_adv_ram (
        .i_clk   (i_clk),
        .i_we    (adv_we),
        .i_waddr (adv_waddr),
        .i_wdata (adv_wdata),
        .i_re    (adv_re),
        .i_raddr (r_idx),
        .o_rdata (adv_rdata)
    );

    gae_mult u_mult (
        .i_clk  (i_clk),
        .i_coef (mul_coef),
        .i_opnd (mul_opnd),
        .o_prod (mul_prod)
    );

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (accept && i_final_step) begin
                    n_state = S_GL;
                end
            end
            S_GL: begin
                n_state = S_VLAST;
            end
            S_VLAST: begin
                n_state = (r_last_idx == '0) ? S_EMIT : S_MUL1;
            end
            S_MUL1: begin
                n_state = S_MUL2;
            end
            S_MUL2: begin
                n_state = S_SUM;
            end
            S_SUM: begin
                n_state = (r_idx == '0) ? S_EMIT : S_MUL1;
            end
            S_EMIT: begin
                if (r_idx == r_last_idx) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        step_we    = 1'b0;
        step_waddr = r_count[ADDR_W-1:0];
        step_re    = 1'b0;
        step_raddr = r_idx - ADDR_W'(1);
        adv_we     = 1'b0;
        adv_waddr  = r_idx;
        adv_wdata  = sum_sat;
        adv_re     = 1'b0;
        mul_coef   = r_gamma;
        mul_opnd   = r_v_next;
        unique case (r_state)
            S_IDLE: begin
                step_we = accept && !store_full;
            end
            S_GL: begin
                mul_opnd   = DATA_W'({1'b0, r_lambda});
                step_re    = 1'b1;
                step_raddr = r_last_idx;
                adv_we     = 1'b1;
                adv_waddr  = r_last_idx;
                adv_wdata  = '0;
            end
            S_VLAST: begin
                step_re    = (r_last_idx != '0);
                step_raddr = r_last_idx - ADDR_W'(1);
            end
            S_MUL1: begin
                mul_coef = r_gamma;
                mul_opnd = r_v_next;
            end
            S_MUL2: begin
                mul_coef = r_gl;
                mul_opnd = r_adv_next;
            end
            S_SUM: begin
                adv_we  = 1'b1;
                step_re = (r_idx != '0);
            end
            S_EMIT: begin
                adv_re = 1'b1;
            end
            default: begin
                step_we = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_gamma      <= GAMMA_RESET;
            r_lambda     <= LAMBDA_RESET;
            r_count      <= '0;
            r_overflow   <= 1'b0;
            r_idx        <= '0;
            r_last_idx   <= '0;
            r_out_strobe <= 1'b0;
            r_out_last   <= 1'b0;
            r_out_trunc  <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_out_strobe <= (r_state == S_EMIT);
            r_out_last   <= (r_state == S_EMIT) && (r_idx == r_last_idx);
            r_out_trunc  <= r_overflow;
            if (i_cfg_valid && o_cfg_ready) begin
                unique case (i_cfg_index)
                    REG_DISCOUNT: r_gamma  <= i_cfg_data;
                    REG_TRACE:    r_lambda <= i_cfg_data;
                    default:      r_gamma  <= r_gamma;
                endcase
            end
            unique case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        if (store_full) begin
                            r_overflow <= 1'b1;
                            r_last_idx <= ADDR_W'(MAX_STEPS - 1);
                        end else begin
                            r_count    <= r_count + CNT_W'(1);
                            r_last_idx <= r_count[ADDR_W-1:0];
                        end
                    end
                end
                S_VLAST: begin
                    r_idx <= (r_last_idx == '0) ? '0 : r_last_idx - ADDR_W'(1);
                end
                S_SUM: begin
                    if (r_idx != '0) begin
                        r_idx <= r_idx - ADDR_W'(1);
                    end
                end
                S_EMIT: begin
                    r_idx <= r_idx + ADDR_W'(1);
                    if (r_idx == r_last_idx) begin
                        r_count    <= '0;
                        r_overflow <= 1'b0;
                    end
                end
                default: begin
                    r_idx <= r_idx;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        unique case (r_state)
            S_VLAST: begin
                r_gl       <= mul_prod[FRAC_W+COEF_W-1:FRAC_W];
                r_v_next   <= step_rd.value;
                r_adv_next <= '0;
            end
            S_MUL1: begin
                r_cur_v    <= step_rd.value;
                r_cur_done <= step_rd.done;
                r_acc      <= ACC_W'(step_rd.reward) - ACC_W'(step_rd.value);
            end
            S_MUL2: begin
                if (!r_cur_done) begin
                    r_acc <= sum;
                end
            end
            S_SUM: begin
                r_adv_next <= sum_sat;
                r_v_next   <= r_cur_v;
            end
            default: begin
                r_acc <= r_acc;
            end
        endcase
    end

    assign o_strobe      = r_out_strobe;
    assign o_advantage   = adv_rdata;
    assign o_last_result = r_out_last;
    assign o_truncated   = r_out_trunc;

`ifndef SYNTH
    a_strobe_after_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> $past(r_state == S_EMIT))
        else $error("result strobe without a preceding emission cycle");

    a_last_has_strobe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_last_result |-> o_strobe)
        else $error("last-result flag outside a result");

    a_final_goes_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_start && !o_busy && i_final_step) |=> o_busy)
        else $error("final item did not start the backward pass");

    a_count_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(MAX_STEPS))
        else $error("step count beyond store capacity");
`endif

endmodule

### hdl/gae_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gae_ram
// Simple dual-port memory with one write port and one registered read port.
// ----------------------------------------------------------------------------
module gae_ram #(
    parameter int DATA_W = 32,
    parameter int ADDR_W = 6
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  logic [DATA_W-1:0] i_wdata,
    input  logic              i_re,
    input  logic [ADDR_W-1:0] i_raddr,
    output logic [DATA_W-1:0] o_rdata
);

    logic [DATA_W-1:0] r_mem [1 << ADDR_W];
    logic [DATA_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

### hdl/gae_mult.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gae_mult
// Shared multiplier: unsigned Q0.16 coefficient times signed operand,
// with the full product registered.
// ----------------------------------------------------------------------------
module gae_mult import gae_pkg::*; (
    input  logic                     i_clk,
    input  logic [COEF_W-1:0]        i_coef,
    input  logic signed [DATA_W-1:0] i_opnd,
    output logic signed [PROD_W-1:0] o_prod
);

    logic signed [PROD_W-1:0] r_prod;
    logic signed [PROD_W-1:0] n_prod;

    always_comb begin
        n_prod = PROD_W'($signed({1'b0, i_coef}) * i_opnd);
    end

    always_ff @(posedge i_clk) begin
        r_prod <= n_prod;
    end

    assign o_prod = r_prod;

endmodule

### verif/gae_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gae_checker
// Watches the step, result and register channels of the advantage engine.
// It keeps its own copy of the stored trajectory and of the coefficients. It
// works out the advantages that each final item is due to produce and
// compares every strobed result with the oldest one still due.
// ----------------------------------------------------------------------------
module gae_checker import gae_pkg::*; (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_start,
    input  logic                     i_busy,
    input  logic signed [DATA_W-1:0] i_reward,
    input  logic signed [DATA_W-1:0] i_value_estimate,
    input  logic                     i_episode_done,
    input  logic                     i_final_step,
    input  logic                     i_strobe,
    input  logic signed [DATA_W-1:0] i_advantage,
    input  logic                     i_last_result,
    input  logic                     i_truncated,
    input  logic                     i_cfg_valid,
    input  logic                     i_cfg_ready,
    input  logic                     i_cfg_index,
    input  logic [COEF_W-1:0]        i_cfg_data,
    output int                       o_pending,
    output int                       o_errors
);

    typedef struct {
        logic signed [DATA_W-1:0] advantage;
        logic                     last_result;
        logic                     truncated;
    } t_adv_result;

    t_adv_result adv_due[$];

    logic signed [DATA_W-1:0] traj_reward [MAX_STEPS];
    logic signed [DATA_W-1:0] traj_value  [MAX_STEPS];
    logic                     traj_done   [MAX_STEPS];
    int unsigned              traj_len;
    logic                     steps_dropped;
    logic [COEF_W-1:0]        gamma_q;
    logic [COEF_W-1:0]        lambda_q;
    int                       err_count;
    int                       result_no;

    task automatic report_mismatch(input string what, input longint got, input longint want);
        $display("%0t ns: result %0d: %s: got %0d, expected %0d",
                 $realtime, result_no, what, got, want);
        err_count++;
    endtask

    function automatic logic signed [DATA_W-1:0] saturate_q16(input longint x);
        if (x > longint'(32'sh7FFF_FFFF))
            return 32'sh7FFF_FFFF;
        if (x < -longint'(32'sh7FFF_FFFF) - 1)
            return 32'sh8000_0000;
        return x[DATA_W-1:0];
    endfunction

    task automatic estimate_advantages();
        longint                   gamma_l;
        longint                   gl_l;
        longint                   acc;
        logic signed [DATA_W-1:0] adv [MAX_STEPS];
        t_adv_result              res;
        int                       k;
        gamma_l = longint'(gamma_q);
        gl_l    = (gamma_l * longint'(lambda_q)) >>> FRAC_W;
        adv[traj_len-1] = '0;
        for (k = traj_len - 1; k > 0; k--) begin
            acc = longint'(traj_reward[k-1]) - longint'(traj_value[k-1]);
            if (!traj_done[k-1])
                acc += (gamma_l * longint'(traj_value[k])) >>> FRAC_W;
            acc += (gl_l * longint'(adv[k])) >>> FRAC_W;
            adv[k-1] = saturate_q16(acc);
        end
        for (k = 0; k < traj_len; k++) begin
            res.advantage   = adv[k];
            res.last_result = (k == traj_len - 1);
            res.truncated   = steps_dropped;
            adv_due.insert(adv_due.size(), res);
        end
    endtask

    always @(posedge i_clk) begin
        t_adv_result want;
        if (!i_rst_n) begin
            adv_due.delete();
            traj_len      = 0;
            steps_dropped = 1'b0;
            gamma_q       = GAMMA_RESET;
            lambda_q      = LAMBDA_RESET;
        end else begin
            if (i_strobe) begin
                if (adv_due.size() == 0) begin
                    report_mismatch("result with none due", longint'(i_advantage), 0);
                end else begin
                    want = adv_due.pop_front();
                    if (i_advantage !== want.advantage)
                        report_mismatch("advantage", longint'(i_advantage),
                                        longint'(want.advantage));
                    if (i_last_result !== want.last_result)
                        report_mismatch("last_result", longint'(i_last_result),
                                        longint'(want.last_result));
                    if (i_truncated !== want.truncated)
                        report_mismatch("truncated", longint'(i_truncated),
                                        longint'(want.truncated));
                end
                result_no++;
            end
            if (i_cfg_valid && i_cfg_ready) begin
                if (i_cfg_index == REG_DISCOUNT)
                    gamma_q = i_cfg_data;
                else if (i_cfg_index == REG_TRACE)
                    lambda_q = i_cfg_data;
            end
            if (i_start && !i_busy) begin
                if (traj_len < MAX_STEPS) begin
                    traj_reward[traj_len] = i_reward;
                    traj_value[traj_len]  = i_value_estimate;
                    traj_done[traj_len]   = i_episode_done;
                    traj_len++;
                end else begin
                    steps_dropped = 1'b1;
                end
                if (i_final_step) begin
                    estimate_advantages();
                    traj_len      = 0;
                    steps_dropped = 1'b0;
                end
            end
        end
        o_pending <= adv_due.size();
        o_errors  <= err_count;
    end

endmodule

### verif/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Testbench of the advantage estimation engine. Directed trajectories with
// extreme rewards and values come first, then random trajectories, mostly
// short with a few that fill or overflow the store, under several discount
// and trace decay settings. The sender idles at random between items; a
// separate checker predicts and compares every result.
// ----------------------------------------------------------------------------
module tb_top import gae_pkg::*; ();

    localparam int PHASE_ITEMS = 4;

    logic                     i_clk            = 1'b0;
    logic                     i_rst_n          = 1'b0;
    logic                     i_start          = 1'b0;
    logic signed [DATA_W-1:0] i_reward         = '0;
    logic signed [DATA_W-1:0] i_value_estimate = '0;
    logic                     i_episode_done   = 1'b0;
    logic                     i_final_step     = 1'b0;
    logic                     i_cfg_valid      = 1'b0;
    logic                     i_cfg_index      = REG_DISCOUNT;
    logic [COEF_W-1:0]        i_cfg_data       = '0;
    logic                     o_busy;
    logic                     o_strobe;
    logic signed [DATA_W-1:0] o_advantage;
    logic                     o_last_result;
    logic                     o_truncated;
    logic                     o_cfg_ready;
    int                       pending;
    int                       errors;
    bit                       calm_sender;

    gae_advantage_engine dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_start          (i_start),
        .o_busy           (o_busy),
        .i_reward         (i_reward),
        .i_value_estimate (i_value_estimate),
        .i_episode_done   (i_episode_done),
        .i_final_step     (i_final_step),
        .o_strobe         (o_strobe),
        .o_advantage      (o_advantage),
        .o_last_result    (o_last_result),
        .o_truncated      (o_truncated),
        .i_cfg_valid      (i_cfg_valid),
        .o_cfg_ready      (o_cfg_ready),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data)
    );

    gae_checker u_checker (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_start          (i_start),
        .i_busy           (o_busy),
        .i_reward         (i_reward),
        .i_value_estimate (i_value_estimate),
        .i_episode_done   (i_episode_done),
        .i_final_step     (i_final_step),
        .i_strobe         (o_strobe),
        .i_advantage      (o_advantage),
        .i_last_result    (o_last_result),
        .i_truncated      (o_truncated),
        .i_cfg_valid      (i_cfg_valid),
        .i_cfg_ready      (o_cfg_ready),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data),
        .o_pending        (pending),
        .o_errors         (errors)
    );

    always #5 i_clk = ~i_clk;

    initial begin
        #(5_000_000);
        $display("tb_top failed");
        $finish;
    end

    function automatic logic signed [DATA_W-1:0] rand_q16();
        if ($urandom_range(0, 3) == 0)
            return $urandom();
        return int'($urandom_range(0, 1048575)) - 524288;
    endfunction

    task automatic write_reg(input logic index, input logic [COEF_W-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= index;
        i_cfg_data  <= data;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
    endtask

    task automatic offer_step(input logic signed [DATA_W-1:0] reward,
                              input logic signed [DATA_W-1:0] value,
                              input logic done, input logic fin);
        int gap;
        gap = calm_sender ? 0 : $urandom_range(0, 8);
        if (gap > 0) begin
            i_start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_start          <= 1'b1;
        i_reward         <= reward;
        i_value_estimate <= value;
        i_episode_done   <= done;
        i_final_step     <= fin;
        @(posedge i_clk);
        while (o_busy) @(posedge i_clk);
    endtask

    task automatic run_trajectory(input int len);
        int k;
        calm_sender = ($urandom_range(0, 3) == 0);
        for (k = 0; k < len; k++)
            offer_step(rand_q16(), rand_q16(), ($urandom_range(0, 3) == 0), k == len - 1);
    endtask

    task automatic set_coefs(input logic [COEF_W-1:0] gamma, input logic [COEF_W-1:0] lambda);
        i_start <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
        write_reg(REG_DISCOUNT, gamma);
        write_reg(REG_TRACE, lambda);
        i_cfg_valid <= 1'b0;
    endtask

    initial begin
        logic [COEF_W-1:0] gammas  [6];
        logic [COEF_W-1:0] lambdas [6];
        int                phase;
        int                sent;
        int                len;
        gammas  = '{16'd0, 16'd65535, 16'd65535, 16'd0, 16'd0, GAMMA_RESET};
        lambdas = '{16'd0, 16'd65535, 16'd0, 16'd65535, 16'd0, LAMBDA_RESET};
        gammas[4]  = COEF_W'($urandom());
        lambdas[4] = COEF_W'($urandom());
        calm_sender = 1'b0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        offer_step(32'sh7FFF_FFFF, 32'sh8000_0000, 1'b0, 1'b1);
        offer_step(32'sh7FFF_FFFF, 32'sh8000_0000, 1'b0, 1'b0);
        offer_step(32'sh8000_0000, 32'sh7FFF_FFFF, 1'b1, 1'b0);
        offer_step(32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 1'b0, 1'b0);
        offer_step(32'sh0000_0000, 32'sh8000_0000, 1'b1, 1'b1);
        offer_step(32'sh0001_0000, 32'sh7FFF_FFFF, 1'b0, 1'b0);
        offer_step(32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 1'b0, 1'b0);
        offer_step(32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 1'b0, 1'b0);
        offer_step(32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 1'b1, 1'b1);
        offer_step(32'sh8000_0000, 32'sh8000_0000, 1'b0, 1'b0);
        offer_step(32'sh8000_0000, 32'sh8000_0000, 1'b0, 1'b0);
        offer_step(32'shFFFF_FFFF, 32'sh0000_0001, 1'b0, 1'b1);

        for (phase = 0; phase < 6; phase++) begin
            set_coefs(gammas[phase], lambdas[phase]);
            offer_step(32'sh8000_0000, 32'sh7FFF_FFFF, 1'b0, 1'b0);
            offer_step(32'sh7FFF_FFFF, 32'sh8000_0000, 1'b0, 1'b1);
            if (phase == 1)
                run_trajectory(MAX_STEPS);
            if (phase == 3)
                run_trajectory(MAX_STEPS + 3);
            sent = 0;
            while (sent < PHASE_ITEMS) begin
                len = $urandom_range(1, 8);
                run_trajectory(len);
                sent += len;
            end
        end

        i_start <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (300) @(posedge i_clk);
        if (errors == 0)
            $display("tb_top passed");
        else
            $display("tb_top failed");
        $finish;
    end

endmodule
